/* design/adl_pkg.sv */
// shared types, widths and constants of the adler-32 engine
package adl_pkg;

   localparam int BytesPerItem = 8;
   localparam int ByteW        = 8;
   localparam int DataW        = BytesPerItem * ByteW;
   localparam int CountW       = 4;
   localparam int SeedW        = 32;
   localparam int HalfW        = 16;
   localparam int CheckW       = 32;
   localparam int ReqDataW     = ((SeedW + DataW + CountW + 7) / 8) * 8;
   localparam int LaneIdxW     = (BytesPerItem > 1) ? $clog2(BytesPerItem) : 1;
   localparam int ProdW        = CountW + ByteW;
   localparam int SumW         = $clog2(BytesPerItem * 255 + 1);
   localparam int WsumW        = $clog2((BytesPerItem * (BytesPerItem + 1) / 2) * 255 + 1);
   localparam int MulW         = CountW + HalfW;
   localparam int BsumW        = MulW + 1;
   localparam int FoldW        = HalfW + 1;
   localparam int AdlerMod     = 65521;
   localparam int FoldMul      = 65536 % AdlerMod;
   localparam int RspDepth     = 3;
   localparam int RspPtrW      = $clog2(RspDepth);
   localparam int RspCntW      = $clog2(RspDepth + 1);

   localparam logic [HalfW-1:0] HalfMask = 16'hffff;
   localparam logic [FoldW-1:0] ModWide  = FoldW'(AdlerMod);

   typedef struct packed {
      logic [ByteW-1:0] contrib;
      logic [ProdW-1:0] weighted;
   } lane_out_type;

   typedef struct packed {
      logic              first;
      logic              last;
      logic [CountW-1:0] n;
      logic [SumW-1:0]   sum;
      logic [WsumW-1:0]  wsum;
      logic [HalfW-1:0]  seed_a;
      logic [HalfW-1:0]  seed_b;
   } stage_type;

   typedef struct packed {
      logic               full;
      logic               empty;
      logic [RspCntW-1:0] count;
   } rsp_status_type;

   function automatic logic [HalfW-1:0] reduce_half(input logic [FoldW-1:0] v);
      logic [FoldW-1:0] r;
      r = (v >= ModWide) ? (v - ModWide) : v;
      return r[HalfW-1:0];
   endfunction

endpackage

/* design/adl_lane.sv */
// one byte lane: gated byte and its position-weighted contribution
module adl_lane (
   input  logic [adl_pkg::LaneIdxW-1:0] lane_idx,
   input  logic [adl_pkg::CountW-1:0]   n,
   input  logic [adl_pkg::ByteW-1:0]    data_byte,
   output adl_pkg::lane_out_type        lane_out
);
   import adl_pkg::*;

   logic              active;
   logic [CountW-1:0] weight;

   assign active  = CountW'(lane_idx) < n;
   assign weight  = active ? (n - CountW'(lane_idx)) : '0;
   assign lane_out.contrib  = active ? data_byte : '0;
   assign lane_out.weighted = ProdW'(weight) * ProdW'(data_byte);
endmodule

/* design/adl_merge.sv */
// lane array and merge stage: sums lane results and reduces the seed
module adl_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      first,
   input  logic                      last,
   input  logic [adl_pkg::SeedW-1:0]  seed,
   input  logic [adl_pkg::DataW-1:0]  data_bytes,
   input  logic [adl_pkg::CountW-1:0] byte_count,
   output logic                      stage_valid,
   output adl_pkg::stage_type        stage
);
   import adl_pkg::*;

   logic [CountW-1:0] n_clamped;
   lane_out_type      lanes [BytesPerItem];
   logic [SumW-1:0]   sum_total;
   logic [WsumW-1:0]  wsum_total;
   stage_type         stage_in;
   stage_type         stage_ff;
   logic              valid_in;
   logic              valid_ff;

   assign n_clamped = (byte_count > CountW'(BytesPerItem)) ? CountW'(BytesPerItem) : byte_count;

   for (genvar g = 0; g < BytesPerItem; g++) begin : g_lane
      adl_lane u_lane (
         .lane_idx  (LaneIdxW'(g)),
         .n         (n_clamped),
         .data_byte (data_bytes[g*ByteW +: ByteW]),
         .lane_out  (lanes[g])
      );
   end

   always_comb begin
      sum_total  = '0;
      wsum_total = '0;
      for (int i = 0; i < BytesPerItem; i++) begin
         sum_total  = sum_total + SumW'(lanes[i].contrib);
         wsum_total = wsum_total + WsumW'(lanes[i].weighted);
      end
      stage_in.first  = first;
      stage_in.last   = last;
      stage_in.n      = n_clamped;
      stage_in.sum    = sum_total;
      stage_in.wsum   = wsum_total;
      stage_in.seed_a = reduce_half(FoldW'(seed[HalfW-1:0]));
      stage_in.seed_b = reduce_half(FoldW'(seed[SeedW-1:HalfW]));
      valid_in        = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;
endmodule

/* design/adl_accum.sv */
// running sum registers: folds one merged request per cycle modulo 65521
module adl_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      stage_valid,
   input  adl_pkg::stage_type        stage,
   output logic                      push,
   output logic [adl_pkg::CheckW-1:0] checksum
);
   import adl_pkg::*;

   logic [HalfW-1:0] sum_a_ff;
   logic [HalfW-1:0] sum_b_ff;
   logic [HalfW-1:0] sum_a_in;
   logic [HalfW-1:0] sum_b_in;
   logic [HalfW-1:0] a_base;
   logic [HalfW-1:0] b_base;
   logic [FoldW-1:0] a_sum;
   logic [MulW-1:0]  prod;
   logic [BsumW-1:0] b_sum;
   logic [FoldW-1:0] b_fold;

   always_comb begin
      a_base   = stage.first ? stage.seed_a : sum_a_ff;
      b_base   = stage.first ? stage.seed_b : sum_b_ff;
      a_sum    = FoldW'(a_base) + FoldW'(stage.sum);
      prod     = MulW'(stage.n) * MulW'(a_base);
      b_sum    = BsumW'(b_base) + BsumW'(prod) + BsumW'(stage.wsum);
      b_fold   = FoldW'(b_sum[HalfW-1:0])
               + FoldW'(b_sum[BsumW-1:HalfW]) * FoldW'(FoldMul);
      sum_a_in = reduce_half(a_sum);
      sum_b_in = reduce_half(b_fold);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= HalfW'(1);
         sum_b_ff <= '0;
      end else if (stage_valid) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

   assign push     = stage_valid & stage.last;
   assign checksum = {sum_b_in & HalfMask, sum_a_in & HalfMask};
endmodule

/* design/adl_rsp_fifo.sv */
// small result queue between the sum registers and the response channel
module adl_rsp_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [adl_pkg::CheckW-1:0] push_data,
   input  logic                       pop,
   output logic [adl_pkg::CheckW-1:0] head_data,
   output adl_pkg::rsp_status_type    status
);
   import adl_pkg::*;

   logic [CheckW-1:0]  mem [RspDepth];
   logic [RspPtrW-1:0] wr_ptr_ff;
   logic [RspPtrW-1:0] rd_ptr_ff;
   logic [RspCntW-1:0] count_ff;
   logic [RspPtrW-1:0] wr_ptr_in;
   logic [RspPtrW-1:0] rd_ptr_in;
   logic [RspCntW-1:0] count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      do_push   = push && (count_ff != RspCntW'(RspDepth));
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == RspPtrW'(RspDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == RspPtrW'(RspDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = mem[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == RspCntW'(RspDepth));
   assign status.empty = (count_ff == '0);
endmodule

/* design/adler32_checksum_engine_top.sv */
// top level of the adler-32 checksum engine
// usage:
//   requests arrive on the req_ channel, up to eight bytes each, earliest byte
//   lowest; req_tuser marks the first request of a buffer (sums load from the
//   seed in req_tdata), req_tlast the final one. a final request yields one
//   checksum on the rsp_ channel, s2 in bits 31:16 and s1 in bits 15:0.
//   the eight byte lanes and their merge take one register stage, and the
//   modulo-65521 fold of the sum registers writes the result queue, whose
//   nonempty state drives rsp_tvalid for the checksum of a last request.
//   throughput: one request per cycle while req_tready is high, set by the sum register loop.
//   the result queue holds three checksums; req_tready drops while the queued
//   checksums plus one still in the merge stage reach three (the receiver
//   holding rsp_tready low) and rises once an entry drains, so no request or
//   checksum is lost.
//   reset: synchronous, active high; clears the queue and the pipeline valid
//   bit and sets the running sums to s1 = 1, s2 = 0.
module adler32_checksum_engine_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [adl_pkg::ReqDataW-1:0]  req_tdata,   // seed, data_bytes, byte_count, zero pad
   input  logic                          req_tuser,   // first
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [adl_pkg::CheckW-1:0]    rsp_tdata    // checksum
);
   import adl_pkg::*;

   logic              req_accept;
   logic              stage_valid;
   stage_type         stage;
   logic              push;
   logic [CheckW-1:0] checksum;
   rsp_status_type    status;
   logic [RspCntW:0]  pending;

   assign pending    = (RspCntW+1)'(status.count) + (RspCntW+1)'(stage_valid & stage.last);
   assign req_tready = pending < (RspCntW+1)'(RspDepth);
   assign req_accept = req_tvalid & req_tready;

   adl_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .first       (req_tuser),
      .last        (req_tlast),
      .seed        (req_tdata[SeedW-1:0]),
      .data_bytes  (req_tdata[SeedW +: DataW]),
      .byte_count  (req_tdata[SeedW+DataW +: CountW]),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   adl_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .push        (push),
      .checksum    (checksum)
   );

   adl_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (checksum),
      .pop       (rsp_tready),
      .head_data (rsp_tdata),
      .status    (status)
   );

   assign rsp_tvalid = !status.empty;

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("result pushed into a full queue");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !req_tready)
      else $error("request taken while the result queue is full");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> ##1 rsp_tvalid)
      else $error("last request did not produce a checksum in time");
`endif
endmodule

/* tb/sv/adler32_checksum_engine_top_tb.sv */
// self-checking testbench of the adler-32 checksum engine top level
module adler32_checksum_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import adl_pkg::*;

   localparam int IdleLimit      = 2000;
   localparam int DrainCycles    = 8;
   localparam int RandomRequests = 1000;
   localparam int ReportLimit    = 10;

   class checksum_tracker;
      logic [HalfW-1:0]  run_s1;
      logic [HalfW-1:0]  run_s2;
      logic [CheckW-1:0] expected_checksums[$];
      int                errors;

      function new();
         run_s1 = HalfW'(1);
         run_s2 = '0;
         errors = 0;
      endfunction

      function int pending();
         return expected_checksums.size();
      endfunction

      function void note_request(logic first, logic [SeedW-1:0] seed, logic [DataW-1:0] data,
                                 logic [CountW-1:0] count, logic last);
         int a;
         int b;
         int n;
         a = int'(run_s1);
         b = int'(run_s2);
         if (first) begin
            a = int'(seed[HalfW-1:0]) % AdlerMod;
            b = int'(seed[SeedW-1:HalfW]) % AdlerMod;
         end
         n = (int'(count) > BytesPerItem) ? BytesPerItem : int'(count);
         for (int i = 0; i < n; i++) begin
            a = a + int'(data[ByteW*i +: ByteW]);
            if (a >= AdlerMod) a = a - AdlerMod;
            b = b + a;
            if (b >= AdlerMod) b = b - AdlerMod;
         end
         run_s1 = a[HalfW-1:0];
         run_s2 = b[HalfW-1:0];
         if (last) expected_checksums.push_back({run_s2, run_s1});
      endfunction

      function void check_checksum(logic [CheckW-1:0] actual);
         logic [CheckW-1:0] want;
         if (expected_checksums.size() == 0) begin
            errors++;
            if (errors <= ReportLimit)
               $display("unexpected checksum %08h with none outstanding", actual);
         end else begin
            want = expected_checksums.pop_front();
            if (actual !== want) begin
               errors++;
               if (errors <= ReportLimit)
                  $display("checksum mismatch: expected %08h, actual %08h", want, actual);
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [CheckW-1:0]   rsp_tdata;

   checksum_tracker tracker;
   int              burst_left = 0;
   int              requests_sent = 0;
   int              idle_cycles = 0;
   int              stall_mode = 0;
   int              mode_cycles = 0;
   int              tick = 0;

   adler32_checksum_engine_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_request(req_tuser, req_tdata[SeedW-1:0], req_tdata[SeedW +: DataW],
                                 req_tdata[SeedW+DataW +: CountW], req_tlast);
         if (rsp_tvalid && rsp_tready) tracker.check_checksum(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("adler32_checksum_engine_top_tb: errors");
            $finish;
         end
      end
   end

   // receiver stall pattern, switching among four modes at random
   always @(posedge clock) begin
      tick <= tick + 1;
      if (reset) begin
         rsp_tready <= 1'b1;
      end else begin
         if (mode_cycles == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            mode_cycles <= $urandom_range(20, 80);
         end else begin
            mode_cycles <= mode_cycles - 1;
         end
         case (stall_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
               rsp_tready <= tick[3];
            end
         endcase
      end
   end

   task automatic send_request(input logic first, input logic [SeedW-1:0] seed,
                               input logic [DataW-1:0] data, input logic [CountW-1:0] count,
                               input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= ReqDataW'({count, data, seed});
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      burst_left = 0;
   endtask

   function automatic logic [HalfW-1:0] pick_half();
      case ($urandom_range(0, 4))
         0: return 16'hffff;
         1: return 16'(AdlerMod);
         2: return 16'(AdlerMod - 1);
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [SeedW-1:0] pick_seed();
      case ($urandom_range(0, 7))
         0: return {pick_half(), pick_half()};
         1: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DataW-1:0] pick_data();
      case ($urandom_range(0, 9))
         0: return '1;
         1: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [CountW-1:0] pick_count();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return CountW'(BytesPerItem);
      if (r < 17) return CountW'($urandom_range(1, BytesPerItem - 1));
      if (r == 17) return '0;
      return CountW'($urandom_range(BytesPerItem + 1, 15));
   endfunction

   initial begin
      int len;
      logic paused;
      tracker = new();
      paused = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // sums straight from reset, then continuing without a seed, then seeded single requests
      send_request(1'b0, 32'h0, 64'h0, 4'd0, 1'b1);
      send_request(1'b0, 32'hffff_ffff, 64'h0000_0000_0000_0061, 4'd1, 1'b1);
      send_request(1'b1, 32'h0000_0001, '1, 4'd8, 1'b1);
      send_request(1'b1, 32'hffff_ffff, '1, 4'd8, 1'b1);
      send_request(1'b1, 32'hfff0_fff0, '1, 4'd8, 1'b1);
      send_request(1'b1, 32'hfff1_fff1, 64'h0123_4567_89ab_cdef, 4'd8, 1'b1);
      send_request(1'b1, 32'h0000_0000, '0, 4'd8, 1'b1);
      // zero count with first and last
      send_request(1'b1, 32'h1234_5678, '1, 4'd0, 1'b1);
      // counts past the lane limit
      send_request(1'b1, 32'h0000_0001, '1, 4'd9, 1'b1);
      send_request(1'b1, 32'hfff0_0005, 64'hfedc_ba98_7654_3210, 4'd15, 1'b1);
      // multi-request buffer, then more without a new seed
      send_request(1'b1, 32'h0000_0001, 64'h6f57_206f_6c6c_6548, 4'd8, 1'b0);
      send_request(1'b0, 32'hffff_ffff, 64'h0000_0000_0064_6c72, 4'd3, 1'b0);
      send_request(1'b0, 32'h0, '1, 4'd8, 1'b1);
      send_request(1'b0, 32'h0, '1, 4'd8, 1'b0);
      send_request(1'b0, 32'h0, 64'h8000_0000_0000_0001, 4'd8, 1'b1);
      for (int c = 1; c < BytesPerItem; c++)
         send_request(1'b1, 32'hffff_0000, '1, CountW'(c), 1'b1);
      pause_until_drained();

      while (requests_sent < RandomRequests) begin
         if (!paused && requests_sent > RandomRequests / 2) begin
            pause_until_drained();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_request(1'($urandom_range(0, 1)), $urandom, pick_data(),
                         CountW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
         end else begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
               send_request(k == 0, pick_seed(), pick_data(), pick_count(), k == len - 1);
         end
      end

      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("adler32_checksum_engine_top_tb: clean");
      end else begin
         $display("adler32_checksum_engine_top_tb: errors");
      end
      $finish;
   end

endmodule

/* files.f */
design/adl_pkg.sv
design/adl_lane.sv
design/adl_merge.sv
design/adl_accum.sv
design/adl_rsp_fifo.sv
design/adler32_checksum_engine_top.sv
tb/sv/adler32_checksum_engine_top_tb.sv
